>>> rtl/core/chvw_pkg.sv
// chvw_pkg: shared types and constants of the code histogram vertex weight core
// used by chvw_div and code_histogram_vertex_weights_core; no dependencies
package chvw_pkg;

	// per-code table entry: presence, occurrence count, attention sum or mean
	typedef struct packed {
		logic        present;
		logic [6:0]  cnt;
		logic [21:0] sum;
	} entry_t;

	// register indexes of the configuration channel
	localparam logic [1:0] REG_WEIGHT_COUNT     = 2'd0;
	localparam logic [1:0] REG_WEIGHT_ATTENTION = 2'd1;
	localparam logic [1:0] REG_USE_MEAN         = 2'd2;

	// shared divider geometry
	localparam int DIV_NW = 48;   // numerator bits
	localparam int DIV_DW = 30;   // denominator bits
	localparam int DIV_QB = 22;   // quotient bits produced
	localparam int DIV_CB = 5;    // step counter bits

	// shared multiplier operand width
	localparam int MUL_W = 24;

endpackage

>>> rtl/core/chvw_div.sv
// chvw_div: iterative restoring divider, one quotient bit a cycle
// depends on chvw_pkg; numerator must be below den shifted up by DIV_QB
module chvw_div
	import chvw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_QB-1:0] quo,
	output logic              rem_nz
);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_QB-1:0] nlow_q;
	logic [DIV_QB-1:0] quo_q;
	logic [DIV_CB-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              take;

	assign trial = {rem_q, nlow_q[DIV_QB-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_CB'(DIV_QB - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DIV_DW'(num[DIV_NW-1:DIV_QB]);
			nlow_q <= num[DIV_QB-1:0];
			den_q  <= den;
		end else if (run_q) begin
			rem_q  <= take ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			nlow_q <= {nlow_q[DIV_QB-2:0], 1'b0};
			quo_q  <= {quo_q[DIV_QB-2:0], take};
		end
	end

	assign done   = done_q;
	assign quo    = quo_q;
	assign rem_nz = rem_q != '0;

endmodule

>>> rtl/core/code_histogram_vertex_weights_core.sv
// code_histogram_vertex_weights_core: per-sample code histogram and vertex weights
// depends on chvw_pkg and chvw_div
//
// usage
//  - input beat: code, attention, last_position taken when start is high and busy low
//  - config: cfg_valid/cfg_ready write of cfg_data into register cfg_index, always ready;
//    write only while idle; unknown indexes are dropped
//  - results: one beat per distinct code of the sample, ascending code order, each on
//    vertex_code/vertex_weight/last_vertex for one cycle with strobe high; last_vertex
//    marks the final beat; the receiver cannot stall, beats are simply presented
//  - a position goes through accept, table read and table write before the next is taken
//  - on the last position a first pass over the list of distinct codes finds the
//    column maxima: per code a list read, table read, evaluation, in mean mode a divide
//  - a second pass walks the code table from 0 up to the highest present code, one entry
//    at a time; each present code uses the shared multiplier (five products) and the
//    22-step divider; the pass clears the presence bits
//  - an empty sample returns to idle with no beats
//  - after reset a clearing pass writes every table entry, busy high meanwhile;
//    config writes are still taken
module code_histogram_vertex_weights_core
	import chvw_pkg::*;
#(
	parameter int CODEBOOK_SIZE = 1024,
	parameter int SEQ_LEN       = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [9:0]         code,
	input  logic [15:0]        attention,
	input  logic               last_position,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               strobe,
	output logic [9:0]         vertex_code,
	output logic signed [16:0] vertex_weight,
	output logic               last_vertex
);

	localparam int AW = $clog2(CODEBOOK_SIZE);
	localparam int LW = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
	localparam int CW = $clog2(SEQ_LEN + 1);

	typedef enum logic [17:0] {
		S_IDLE   = 18'b000000000000000001,
		S_CLR    = 18'b000000000000000010,
		S_ACC_RD = 18'b000000000000000100,
		S_ACC_WR = 18'b000000000000001000,
		S_P1_RL  = 18'b000000000000010000,
		S_P1_RM  = 18'b000000000000100000,
		S_P1_EV  = 18'b000000000001000000,
		S_P1_DIV = 18'b000000000010000000,
		S_P2_RD  = 18'b000000000100000000,
		S_P2_EV  = 18'b000000001000000000,
		S_MUL1   = 18'b000000010000000000,
		S_MUL2   = 18'b000000100000000000,
		S_MUL3   = 18'b000001000000000000,
		S_MUL4   = 18'b000010000000000000,
		S_MUL5   = 18'b000100000000000000,
		S_SUM    = 18'b001000000000000000,
		S_NEG    = 18'b010000000000000000,
		S_DIV    = 18'b100000000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [15:0] wc_q, wa_q;
	logic               mean_q;

	// captured input beat
	logic [9:0]  code_q;
	logic [15:0] att_q;
	logic        last_q;

	// sample bookkeeping
	logic [CW-1:0] pos_q;     // positions taken
	logic [CW-1:0] nlist_q;   // distinct codes
	logic [CW-1:0] slot_q;    // first pass index
	logic [CW-1:0] emit_q;    // beats given
	logic [AW-1:0] walk_q;    // clear and second pass address

	// column maxima and current code attributes
	logic [6:0]  cmax_q, c_q;
	logic [21:0] amax_q, a_q;

	// product and quotient registers
	logic signed [47:0] t1_q, t2_q, t3_q, nval_q;
	logic [28:0]        den_q;
	logic               neg_q;

	// code table and distinct-code list
	entry_t      table_mem [CODEBOOK_SIZE];
	entry_t      ent_q;
	logic [9:0]  list_mem [SEQ_LEN];
	logic [9:0]  list_rd_q;

	logic [AW-1:0] raddr, waddr;
	logic          we, list_we;
	entry_t        wdata;

	logic [16:0]   code_ext, list_ext, walk_ext;
	logic [AW-1:0] code_addr, list_addr;
	logic          code_ok, acc_ok;
	entry_t        acc_ent;
	logic [CW-1:0] nlist_next;

	// shared multiplier
	logic signed [MUL_W-1:0]   ma, mb;
	logic signed [2*MUL_W-1:0] prod;
	logic [21:0]               aprime;

	// shared divider
	logic              div_start, div_done, div_rnz;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic [DIV_QB-1:0] div_quo;

	// final weight
	logic signed [23:0] q_ext, q_adj, q_res;
	logic signed [16:0] w_sat;
	logic               is_last;

	assign busy      = state_q != S_IDLE;
	assign cfg_ready = 1'b1;

	assign code_ext  = 17'(code_q);
	assign code_addr = code_ext[AW-1:0];
	assign list_ext  = 17'(list_rd_q);
	assign list_addr = list_ext[AW-1:0];
	assign walk_ext  = 17'(walk_q);
	assign code_ok   = 32'(code_q) < 32'(CODEBOOK_SIZE);
	assign acc_ok    = code_ok && (pos_q < CW'(SEQ_LEN));

	assign aprime = (amax_q == '0) ? 22'd1 : amax_q;
	assign prod   = ma * mb;

	// accumulate update of the table entry just read
	always_comb begin
		acc_ent.present = 1'b1;
		if (ent_q.present) begin
			acc_ent.cnt = ent_q.cnt + 7'd1;
			acc_ent.sum = ent_q.sum + 22'(att_q);
		end else begin
			acc_ent.cnt = 7'd1;
			acc_ent.sum = 22'(att_q);
		end
		nlist_next = (acc_ok && !ent_q.present) ? nlist_q + 1'b1 : nlist_q;
	end

	// table port, divider and multiplier operand selection
	always_comb begin
		raddr     = walk_q;
		we        = 1'b0;
		waddr     = walk_q;
		wdata     = '0;
		list_we   = 1'b0;
		div_start = 1'b0;
		div_num   = DIV_NW'(nval_q);
		div_den   = {den_q, 1'b0};
		ma        = '0;
		mb        = '0;
		unique case (state_q)
			S_CLR: begin
				we = 1'b1;
			end
			S_ACC_RD: begin
				raddr = code_addr;
			end
			S_ACC_WR: begin
				raddr   = code_addr;
				we      = acc_ok;
				waddr   = code_addr;
				wdata   = acc_ent;
				list_we = acc_ok && !ent_q.present;
			end
			S_P1_RM, S_P1_EV: begin
				raddr = list_addr;
			end
			S_P1_DIV: begin
				raddr = list_addr;
				if (div_done) begin
					we    = 1'b1;
					waddr = list_addr;
					wdata = '{present: 1'b1, cnt: c_q, sum: div_quo};
				end
			end
			S_P2_EV: begin
				we    = ent_q.present;
				wdata = '{present: 1'b0, cnt: ent_q.cnt, sum: ent_q.sum};
			end
			S_MUL1: begin
				ma = MUL_W'(wc_q);
				mb = MUL_W'(c_q);
			end
			S_MUL2: begin
				ma = t1_q[MUL_W-1:0];
				mb = MUL_W'(aprime);
			end
			S_MUL3: begin
				ma = MUL_W'(wa_q);
				mb = MUL_W'(cmax_q);
			end
			S_MUL4: begin
				ma = t3_q[MUL_W-1:0];
				mb = MUL_W'(a_q);
			end
			S_MUL5: begin
				ma = MUL_W'(cmax_q);
				mb = MUL_W'(aprime);
			end
			S_NEG: begin
				div_start = 1'b1;
				div_num   = nval_q[47] ? DIV_NW'(-nval_q) : DIV_NW'(nval_q);
			end
			default: begin
			end
		endcase
		if (state_q == S_P1_EV && mean_q) begin
			div_start = 1'b1;
			div_num   = DIV_NW'(ent_q.sum);
			div_den   = DIV_DW'(ent_q.cnt);
		end
	end

	// floor of the signed quotient, then saturation to the output range
	always_comb begin
		q_ext = 24'(div_quo);
		q_adj = q_ext + 24'(div_rnz);
		q_res = neg_q ? -q_adj : q_ext;
		if (q_res > 24'sd65535) begin
			w_sat = 17'sd65535;
		end else if (q_res < -24'sd65536) begin
			w_sat = -17'sd65536;
		end else begin
			w_sat = q_res[16:0];
		end
		is_last = (emit_q + 1'b1) == nlist_q;
	end

	chvw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem_nz (div_rnz)
	);

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (we) begin
			table_mem[waddr] <= wdata;
		end
		ent_q <= table_mem[raddr];
		if (list_we) begin
			list_mem[nlist_q[LW-1:0]] <= code_q;
		end
		list_rd_q <= list_mem[slot_q[LW-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q   <= 16'sd4096;
			wa_q   <= 16'sd4096;
			mean_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WEIGHT_COUNT:     wc_q   <= cfg_data;
				REG_WEIGHT_ATTENTION: wa_q   <= cfg_data;
				REG_USE_MEAN:         mean_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			walk_q  <= '0;
			pos_q   <= '0;
			nlist_q <= '0;
			slot_q  <= '0;
			emit_q  <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_ACC_RD;
					end
				end
				S_CLR: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == AW'(CODEBOOK_SIZE - 1)) begin
						walk_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_ACC_RD: begin
					state_q <= S_ACC_WR;
				end
				S_ACC_WR: begin
					nlist_q <= nlist_next;
					if (acc_ok) begin
						pos_q <= pos_q + 1'b1;
					end
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (nlist_next == '0) begin
						// empty sample
						pos_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						slot_q  <= '0;
						emit_q  <= '0;
						walk_q  <= '0;
						state_q <= S_P1_RL;
					end
				end
				S_P1_RL: begin
					state_q <= S_P1_RM;
				end
				S_P1_RM: begin
					state_q <= S_P1_EV;
				end
				S_P1_EV: begin
					if (mean_q) begin
						state_q <= S_P1_DIV;
					end else begin
						slot_q  <= slot_q + 1'b1;
						state_q <= (slot_q + 1'b1 == nlist_q) ? S_P2_RD : S_P1_RL;
					end
				end
				S_P1_DIV: begin
					if (div_done) begin
						slot_q  <= slot_q + 1'b1;
						state_q <= (slot_q + 1'b1 == nlist_q) ? S_P2_RD : S_P1_RL;
					end
				end
				S_P2_RD: begin
					state_q <= S_P2_EV;
				end
				S_P2_EV: begin
					if (ent_q.present) begin
						state_q <= S_MUL1;
					end else begin
						walk_q  <= walk_q + 1'b1;
						state_q <= S_P2_RD;
					end
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_MUL3;
				S_MUL3:  state_q <= S_MUL4;
				S_MUL4:  state_q <= S_MUL5;
				S_MUL5:  state_q <= S_SUM;
				S_SUM:   state_q <= S_NEG;
				S_NEG:   state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						strobe <= 1'b1;
						emit_q <= emit_q + 1'b1;
						if (is_last) begin
							pos_q   <= '0;
							nlist_q <= '0;
							walk_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							walk_q  <= walk_q + 1'b1;
							state_q <= S_P2_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			code_q <= code;
			att_q  <= attention;
			last_q <= last_position;
		end
		// first pass: column maxima, mean written back over the sum
		if (state_q == S_ACC_WR) begin
			cmax_q <= '0;
			amax_q <= '0;
		end
		if (state_q == S_P1_EV) begin
			c_q <= ent_q.cnt;
			if (ent_q.cnt > cmax_q) begin
				cmax_q <= ent_q.cnt;
			end
			if (!mean_q && ent_q.sum > amax_q) begin
				amax_q <= ent_q.sum;
			end
		end
		if (state_q == S_P1_DIV && div_done && div_quo > amax_q) begin
			amax_q <= div_quo;
		end
		// second pass: attributes of the present code
		if (state_q == S_P2_EV) begin
			c_q <= ent_q.cnt;
			a_q <= ent_q.sum;
		end
		if (state_q == S_MUL1) t1_q <= prod;
		if (state_q == S_MUL2) t2_q <= prod;
		if (state_q == S_MUL3) t3_q <= prod;
		if (state_q == S_MUL4) t3_q <= prod;
		if (state_q == S_MUL5) den_q <= prod[28:0];
		// rounded numerator: 2 * num + den
		if (state_q == S_SUM) nval_q <= ((t2_q + t3_q) <<< 1) + 48'(den_q);
		if (state_q == S_NEG) neg_q <= nval_q[47];
		if (state_q == S_DIV && div_done) begin
			vertex_code   <= walk_ext[9:0];
			vertex_weight <= w_sat;
			last_vertex   <= is_last;
		end
	end

endmodule

>>> tb/sv/tb_code_histogram_vertex_weights_core.sv
// tb_code_histogram_vertex_weights_core: self-checking bench for the vertex weight core
// depends on chvw_pkg and code_histogram_vertex_weights_core; drives samples and
// configuration beats, predicts every vertex beat and checks it field by field
module tb_code_histogram_vertex_weights_core
	import chvw_pkg::*;
();

	localparam int          CODES      = 1024;
	localparam int          MAX_POS    = 64;
	localparam logic [1:0]  REG_SPARE  = 2'd3;    // no register behind this index
	localparam int          SETTLE     = 60;      // quiet cycles before a config write
	localparam int          STALL_MAX  = 50000;   // cycles with no beat at all
	localparam int          RAND_ITEMS = 400;

	typedef enum logic {K_POS, K_CFG} beat_kind_t;

	typedef struct {
		beat_kind_t  kind;
		logic [9:0]  code;
		logic [15:0] att;
		logic        last;
		logic [1:0]  idx;
		logic [15:0] data;
		bit          rush;    // never idle in front of this beat
	} beat_t;

	typedef struct {
		logic [9:0]         code;
		logic signed [16:0] weight;
		logic               last;
	} vertex_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [9:0]         code;
	logic [15:0]        attention;
	logic               last_position;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               strobe;
	logic [9:0]         vertex_code;
	logic signed [16:0] vertex_weight;
	logic               last_vertex;

	code_histogram_vertex_weights_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.code(code), .attention(attention), .last_position(last_position),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .strobe(strobe), .vertex_code(vertex_code),
		.vertex_weight(vertex_weight), .last_vertex(last_vertex)
	);

	// beats still to send, and vertex beats owed by the core
	beat_t   pending_q[$];
	vertex_t vertex_q[$];

	// predicted core state
	logic signed [15:0] w_count;
	logic signed [15:0] w_att;
	logic               mean_mode;
	bit                 seen_code[CODES];
	logic [6:0]         code_cnt[CODES];
	logic [21:0]        code_sum[CODES];
	int                 positions;

	// handshake flags from the last rising edge, read by the driver
	bit pos_taken;
	bit cfg_taken;
	int quiet;
	int stall;
	int errors;
	int rand_items;

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	function automatic longint attr_of(int i);
		if (mean_mode)
			return longint'(code_sum[i]) / longint'(code_cnt[i]);
		return longint'(code_sum[i]);
	endfunction

	// fold one position into the histogram; on the last one owe a vertex beat per code
	function automatic void histogram_step(beat_t b);
		longint  wc, wa, cm, am, c, a, num, den, q;
		int      npresent, k;
		vertex_t v;
		if (positions < MAX_POS) begin
			if (!seen_code[b.code]) begin
				seen_code[b.code] = 1;
				code_cnt[b.code]  = '0;
				code_sum[b.code]  = '0;
			end
			code_cnt[b.code] = code_cnt[b.code] + 7'd1;
			code_sum[b.code] = code_sum[b.code] + 22'(b.att);
			positions++;
		end
		if (!b.last)
			return;
		wc = longint'(w_count);
		wa = longint'(w_att);
		cm = 0;
		am = 0;
		npresent = 0;
		for (int i = 0; i < CODES; i++) begin
			if (seen_code[i]) begin
				npresent++;
				if (longint'(code_cnt[i]) > cm) cm = longint'(code_cnt[i]);
				if (attr_of(i) > am) am = attr_of(i);
			end
		end
		k = 0;
		for (int i = 0; i < CODES; i++) begin
			if (seen_code[i]) begin
				k++;
				c = longint'(code_cnt[i]);
				a = attr_of(i);
				if (cm == 0) begin
					num = 0;
					den = 1;
				end else if (am == 0) begin
					// no attention at all: count term alone
					num = wc * c;
					den = cm;
				end else begin
					num = wc * c * am + wa * a * cm;
					den = cm * am;
				end
				// round half up as a floor of (2n + d) / 2d
				q = (2 * num + den) / (2 * den);
				if (((2 * num + den) % (2 * den)) != 0 && (2 * num + den) < 0)
					q--;
				if (q > 65535) q = 65535;
				if (q < -65536) q = -65536;
				v.code   = 10'(i);
				v.weight = 17'(q);
				v.last   = (k == npresent);
				vertex_q.insert(vertex_q.size(), v);
				seen_code[i] = 0;
			end
		end
		positions = 0;
	endfunction

	function automatic void apply_config(logic [1:0] idx, logic [15:0] data);
		case (idx)
			REG_WEIGHT_COUNT: begin
				w_count = data;
			end
			REG_WEIGHT_ATTENTION: begin
				w_att = data;
			end
			REG_USE_MEAN: begin
				mean_mode = data[0];
			end
			default: begin
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic void add_pos(int c, int att, bit last, bit rush);
		beat_t b;
		b.kind = K_POS;
		b.code = 10'(c);
		b.att  = 16'(att);
		b.last = last;
		b.idx  = '0;
		b.data = '0;
		b.rush = rush;
		pending_q.insert(pending_q.size(), b);
	endfunction

	function automatic void add_cfg(logic [1:0] idx, logic [15:0] data);
		beat_t b;
		b.kind = K_CFG;
		b.code = '0;
		b.att  = '0;
		b.last = 0;
		b.idx  = idx;
		b.data = data;
		b.rush = 0;
		pending_q.insert(pending_q.size(), b);
	endfunction

	// one random sample; codes drawn from a window so that codes repeat
	function automatic int add_sample(int len, bit rush);
		int base, span, att, mode;
		base = $urandom_range(CODES - 1);
		span = ($urandom_range(3) == 0) ? CODES : $urandom_range(1, 40);
		mode = $urandom_range(9);
		for (int p = 0; p < len; p++) begin
			case (mode)
				0:       att = 0;
				1:       att = ($urandom_range(1) != 0) ? 65535 : 0;
				2:       att = $urandom_range(15);
				default: att = $urandom_range(65535);
			endcase
			add_pos((base + $urandom_range(span - 1)) % CODES, att, p == len - 1, rush);
		end
		return len;
	endfunction

	function automatic void add_random_config();
		int sel;
		sel = $urandom_range(5);
		case (sel)
			0:       add_cfg(REG_WEIGHT_COUNT, 16'h8000);
			1:       add_cfg(REG_WEIGHT_COUNT, 16'h7fff);
			default: add_cfg(REG_WEIGHT_COUNT, 16'($urandom_range(65535)));
		endcase
		sel = $urandom_range(5);
		case (sel)
			0:       add_cfg(REG_WEIGHT_ATTENTION, 16'h8000);
			1:       add_cfg(REG_WEIGHT_ATTENTION, 16'h7fff);
			default: add_cfg(REG_WEIGHT_ATTENTION, 16'($urandom_range(65535)));
		endcase
		add_cfg(REG_USE_MEAN, 16'($urandom_range(65535)));
		if ($urandom_range(4) == 0)
			add_cfg(REG_SPARE, 16'($urandom_range(65535)));
	endfunction

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin
		if (arst_n) begin
			// input side: hold a beat the core has not taken yet
			if (start && !pos_taken) begin
				start <= 1'b1;
			end else if (pending_q.size() > 0 && pending_q[0].kind == K_POS &&
				(pending_q[0].rush || $urandom_range(99) >= 31)) begin
				start         <= 1'b1;
				code          <= pending_q[0].code;
				attention     <= pending_q[0].att;
				last_position <= pending_q[0].last;
			end else begin
				start         <= 1'b0;
				code          <= 10'($urandom);
				attention     <= 16'($urandom);
				last_position <= 1'($urandom);
			end
			// config side: only once the core has gone quiet
			if (cfg_valid && !cfg_taken) begin
				cfg_valid <= 1'b1;
			end else if (pending_q.size() > 0 && pending_q[0].kind == K_CFG &&
				quiet >= SETTLE && $urandom_range(99) >= 31) begin
				cfg_valid <= 1'b1;
				cfg_index <= pending_q[0].idx;
				cfg_data  <= pending_q[0].data;
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		if (arst_n) begin
			pos_taken = start && !busy;
			cfg_taken = cfg_valid && cfg_ready;
			// check the vertex beat first: it belongs to an earlier sample
			if (strobe) begin
				if (vertex_q.size() == 0) begin
					$error("unexpected vertex beat: code %0d weight %0d last %0d",
						vertex_code, vertex_weight, last_vertex);
					errors++;
				end else begin
					if (vertex_code !== vertex_q[0].code) begin
						$error("vertex_code: expected %0d, got %0d",
							vertex_q[0].code, vertex_code);
						errors++;
					end
					if (vertex_weight !== vertex_q[0].weight) begin
						$error("vertex_weight: expected %0d, got %0d",
							vertex_q[0].weight, vertex_weight);
						errors++;
					end
					if (last_vertex !== vertex_q[0].last) begin
						$error("last_vertex: expected %0d, got %0d",
							vertex_q[0].last, last_vertex);
						errors++;
					end
					void'(vertex_q.pop_front());
				end
			end
			if (pos_taken) begin
				histogram_step(pending_q[0]);
				void'(pending_q.pop_front());
			end
			if (cfg_taken) begin
				apply_config(cfg_index, cfg_data);
				void'(pending_q.pop_front());
			end
			// quiet time gates config writes
			if (vertex_q.size() == 0 && !busy && !start)
				quiet++;
			else
				quiet = 0;
			// watchdog on cycles with no beat accepted anywhere
			if (pos_taken || cfg_taken || strobe)
				stall = 0;
			else
				stall++;
			if (stall >= STALL_MAX) begin
				$display("code_histogram_vertex_weights_core: mismatch");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		code          = '0;
		attention     = '0;
		last_position = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		w_count       = 16'sd4096;
		w_att         = 16'sd4096;
		mean_mode     = 1'b1;
		positions     = 0;
		errors        = 0;
		quiet         = 0;
		stall         = 0;
		rand_items    = 0;
		for (int i = 0; i < CODES; i++) begin
			seen_code[i] = 0;
			code_cnt[i]  = '0;
			code_sum[i]  = '0;
		end

		// directed, reset weights: single code with no attention
		add_pos(0, 0, 1, 0);
		// lowest and highest code, extreme attention
		add_pos(1023, 65535, 0, 0);
		add_pos(0, 0, 0, 0);
		add_pos(1023, 65535, 1, 0);
		// mean rounds down: sum 3 over count 2
		add_pos(5, 1, 0, 0);
		add_pos(5, 2, 0, 0);
		add_pos(6, 65535, 1, 0);
		// positions past the sequence length are dropped, last still honoured
		for (int p = 0; p < 70; p++)
			add_pos(p % 3 + 100, 16'(p * 997), p == 69, 1);
		// largest positive weights with summed attention, spare index ignored
		add_cfg(REG_WEIGHT_COUNT, 16'h7fff);
		add_cfg(REG_WEIGHT_ATTENTION, 16'h7fff);
		add_cfg(REG_USE_MEAN, 16'h0000);
		add_cfg(REG_SPARE, 16'h1234);
		add_pos(7, 65535, 0, 0);
		add_pos(8, 65535, 1, 0);
		// negative weights in mean mode
		add_cfg(REG_WEIGHT_COUNT, 16'h8000);
		add_cfg(REG_WEIGHT_ATTENTION, 16'h8000);
		add_cfg(REG_USE_MEAN, 16'hffff);
		add_pos(9, 40000, 0, 0);
		add_pos(9, 1, 0, 0);
		add_pos(10, 65535, 1, 0);
		// zero count weight
		add_cfg(REG_WEIGHT_COUNT, 16'h0000);
		add_cfg(REG_WEIGHT_ATTENTION, 16'h1800);
		add_pos(11, 300, 0, 0);
		add_pos(12, 0, 1, 0);

		// random phases; a middle stretch runs with no idling
		while (rand_items < RAND_ITEMS) begin
			add_random_config();
			for (int s = $urandom_range(2, 4); s > 0; s--)
				rand_items += add_sample(($urandom_range(9) == 0) ?
					$urandom_range(60, 80) : $urandom_range(1, 24),
					rand_items >= 150 && rand_items < 250);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() > 0 || vertex_q.size() > 0)
			@(posedge clk);
		// any stray beat would show within a short tail
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("code_histogram_vertex_weights_core: match");
		else
			$display("code_histogram_vertex_weights_core: mismatch");
		$finish;
	end

endmodule

>>> code_histogram_vertex_weights_core.f
rtl/core/chvw_pkg.sv
rtl/core/chvw_div.sv
rtl/core/code_histogram_vertex_weights_core.sv
tb/sv/tb_code_histogram_vertex_weights_core.sv
